[rtl/sflm_pkg.sv]
// ----------------------------------------------------------------------------
// sflm_pkg: shared types and constants for the substring search block
// Holds the word types of the in and out channels, the configuration register codes,
// the cell control struct and the pattern length clamp.
// ----------------------------------------------------------------------------
package sflm_pkg;

  // Buffer capacity in bytes and the number of comparison cells.
  localparam int MAX_BUFFER  = 2048;
  localparam int MAX_PATTERN = 16;

  // Pattern storage is fixed by the two 64-bit pattern registers.
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;
  localparam int LEN_W      = 5;
  localparam int CELL_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int COUNT_W    = $clog2(MAX_BUFFER + 2);
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW     = 2'd0,
    CFG_PATTERN_HIGH    = 2'd1,
    CFG_PATTERN_LENGTH  = 2'd2,
    CFG_SEARCH_BACKWARD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             overflow;
  } out_word_t;

  // Control handed to every cell of the window chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  // Lengths above the cell count behave as the full cell count.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    begin
      res = (len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len;
      return res;
    end
  endfunction

endpackage

[rtl/sflm_cell.sv]
// ----------------------------------------------------------------------------
// sflm_cell: one byte cell of the search window
// Holds one window byte, passes it to the next cell on every shift and
// compares the incoming byte with the pattern byte aligned to its place.
// ----------------------------------------------------------------------------
module sflm_cell (
  input  logic                           clk,
  input  sflm_pkg::cell_ctl_t            ctl,
  input  logic [sflm_pkg::CELL_IDX_W-1:0] cell_idx,
  input  logic [7:0]                     byte_in,
  input  sflm_pkg::pattern_t             pattern,
  input  logic [sflm_pkg::LEN_W-1:0]     len_eff,
  output logic [7:0]                     byte_out,
  output logic                           match
);
  import sflm_pkg::*;

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic [LEN_W-1:0] pat_sel;
  logic             in_use;

  // This cell takes part only while its place lies inside the pattern; the
  // newest byte lines up with the last pattern byte.
  always_comb begin
    in_use  = LEN_W'(cell_idx) < len_eff;
    pat_sel = len_eff - LEN_W'(1) - LEN_W'(cell_idx);
    match   = !in_use || (byte_in == pattern[pat_sel[PAT_IDX_W-1:0]]);
  end

  // Shift the incoming byte in, or empty the cell at the end of a buffer.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = ctl.clear ? 8'h00 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;

endmodule

[rtl/sflm_tracker.sv]
// ----------------------------------------------------------------------------
// sflm_tracker: byte count and match position tracking
// Counts the bytes of the current buffer, records the first and last match
// starts and forms the result word for the byte that ends the buffer.
// ----------------------------------------------------------------------------
module sflm_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       last,
  input  logic                       all_match,
  input  logic [sflm_pkg::LEN_W-1:0] len_eff,
  input  logic                       search_backward,
  output sflm_pkg::out_word_t        result
);
  import sflm_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               cap_r, cap_nxt;
  logic               first_seen_r, first_seen_nxt;
  logic [POS_W-1:0]   first_pos_r, first_pos_nxt;
  logic               last_seen_r, last_seen_nxt;
  logic [POS_W-1:0]   last_pos_r, last_pos_nxt;

  logic [COUNT_W-1:0] count_new;
  logic               cap_new;
  logic               hit;
  logic [COUNT_W-1:0] start_full;
  logic               first_seen_new, last_seen_new;
  logic [POS_W-1:0]   first_pos_new, last_pos_new;

  // Count with saturation one past capacity, then qualify the window hit.
  always_comb begin
    count_new  = (count_r <= COUNT_W'(MAX_BUFFER)) ? count_r + COUNT_W'(1) : count_r;
    cap_new    = cap_r || (count_new > COUNT_W'(MAX_BUFFER));
    hit        = all_match && (len_eff != '0) && !cap_new &&
                 (count_new >= COUNT_W'(len_eff));
    start_full = count_new - COUNT_W'(len_eff);

    first_seen_new = first_seen_r || hit;
    first_pos_new  = (hit && !first_seen_r) ? start_full[POS_W-1:0] : first_pos_r;
    last_seen_new  = last_seen_r || hit;
    last_pos_new   = hit ? start_full[POS_W-1:0] : last_pos_r;
  end

  // Result word for a byte that ends the buffer.
  always_comb begin
    result = '0;
    if (cap_new) begin
      result.overflow = 1'b1;
    end else if (search_backward) begin
      result.found          = last_seen_new;
      result.match_position = last_seen_new ? last_pos_new : '0;
    end else begin
      result.found          = first_seen_new;
      result.match_position = first_seen_new ? first_pos_new : '0;
    end
  end

  // Update on every accepted byte; the end of a buffer clears it all.
  always_comb begin
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    first_seen_nxt = first_seen_r;
    first_pos_nxt  = first_pos_r;
    last_seen_nxt  = last_seen_r;
    last_pos_nxt   = last_pos_r;
    if (accept) begin
      if (last) begin
        count_nxt      = '0;
        cap_nxt        = 1'b0;
        first_seen_nxt = 1'b0;
        first_pos_nxt  = '0;
        last_seen_nxt  = 1'b0;
        last_pos_nxt   = '0;
      end else begin
        count_nxt      = count_new;
        cap_nxt        = cap_new;
        first_seen_nxt = first_seen_new;
        first_pos_nxt  = first_pos_new;
        last_seen_nxt  = last_seen_new;
        last_pos_nxt   = last_pos_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cap_r        <= 1'b0;
      first_seen_r <= 1'b0;
      first_pos_r  <= '0;
      last_seen_r  <= 1'b0;
      last_pos_r   <= '0;
    end else begin
      count_r      <= count_nxt;
      cap_r        <= cap_nxt;
      first_seen_r <= first_seen_nxt;
      first_pos_r  <= first_pos_nxt;
      last_seen_r  <= last_seen_nxt;
      last_pos_r   <= last_pos_nxt;
    end
  end

endmodule

[rtl/substring_first_last_match.sv]
// ----------------------------------------------------------------------------
// substring_first_last_match: streaming substring search
// Searches each buffer for a configured pattern of 1 to 16 bytes and gives
// one word per buffer with the first or last match start.
//
//   Channel  Direction  Handshake          Word
//   in       input      in_valid/in_stall  data_byte, end_of_buffer
//   out      output     out_valid/out_stall found, match_position, overflow
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle while the input is not stalled; every cell
// compares its incoming byte in the cycle the byte is taken. The result
// word appears in the output register in the cycle after the byte that
// ends the buffer. Synchronous reset clears all control state and sets
// the pattern length to one. Input is stalled only while a result word is
// held and the output side is stalling.
// ----------------------------------------------------------------------------
module substring_first_last_match (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sflm_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sflm_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sflm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sflm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sflm_pkg::*;

  // Configuration registers.
  pattern_t         pattern_r, pattern_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             backward_r, backward_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic                  in_accept;
  logic [LEN_W-1:0]      len_eff;
  cell_ctl_t             ctl;
  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0][7:0] cell_byte_in;
  logic [MAX_PATTERN-1:0][7:0] cell_byte_out;
  out_word_t             result;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign len_eff   = eff_len(plen_r);

  // Register writes.
  always_comb begin
    pattern_nxt  = pattern_r;
    plen_nxt     = plen_r;
    backward_nxt = backward_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LOW:     pattern_nxt[7:0]  = cfg_data;
        CFG_PATTERN_HIGH:    pattern_nxt[15:8] = cfg_data;
        CFG_PATTERN_LENGTH:  plen_nxt          = cfg_data[LEN_W-1:0];
        CFG_SEARCH_BACKWARD: backward_nxt      = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Window chain: cell zero takes the new byte, each cell feeds the next.
  assign ctl.shift = in_accept;
  assign ctl.clear = in_word.end_of_buffer;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_byte_in[j] = in_word.data_byte;
    end else begin : g_body
      assign cell_byte_in[j] = cell_byte_out[j-1];
    end

    sflm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (CELL_IDX_W'(j)),
      .byte_in  (cell_byte_in[j]),
      .pattern  (pattern_r),
      .len_eff  (len_eff),
      .byte_out (cell_byte_out[j]),
      .match    (cell_match[j])
    );
  end

  sflm_tracker u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .last            (in_word.end_of_buffer),
    .all_match       (&cell_match),
    .len_eff         (len_eff),
    .search_backward (backward_r),
    .result          (result)
  );

  // Output register: loads on the byte that ends a buffer, drains when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (in_accept && in_word.end_of_buffer) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = result;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      plen_r      <= LEN_W'(1);
      backward_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pattern_r   <= pattern_nxt;
      plen_r      <= plen_nxt;
      backward_r  <= backward_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A word that ends a buffer always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_word.end_of_buffer |=> out_valid_r)
    else $error("result word missing after end of buffer");

  // Overflow never comes with a match.
  a_overflow_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.overflow && out_word_r.found))
    else $error("overflow reported together with a match");

  // Position is zero whenever nothing was found.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.found |-> out_word_r.match_position == '0)
    else $error("non-zero position without a match");

  // Input is held back only by a waiting result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty output register");

endmodule
